/* src/min_line_segment_tree_assert.svh */
// Assertion macros for the min line segment tree block.
`ifndef MIN_LINE_SEGMENT_TREE_ASSERT_SVH
`define MIN_LINE_SEGMENT_TREE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define MLST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlst: implication check failed");

// Next-cycle implication, checked out of reset.
`define MLST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlst: next-cycle check failed");

`else

`define MLST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MLST_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/mlst_pkg.sv */
// Types and constants for the min line segment tree block.
package mlst_pkg;

  localparam int FUNC_W  = 2;
  localparam int SLOPE_W = 32;
  localparam int ICPT_W  = 62;
  localparam int POS_W   = 10;
  localparam int MIN_W   = 63;
  localparam int VAL_W   = 64;
  localparam int OPA_W   = SLOPE_W + 1;
  localparam int OPB_W   = ICPT_W + 1;
  localparam int LINE_W  = SLOPE_W + ICPT_W;

  // empty line: slope 0, intercept 2^60
  localparam logic signed [ICPT_W-1:0] EMPTY_ICPT = 62'sh1000_0000_0000_0000;
  localparam logic signed [VAL_W-1:0]  EMPTY_VAL  = 64'sh1000_0000_0000_0000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_t;

  typedef enum logic [9:0] {
    S_CLR     = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_RD      = 10'b00_0000_0100,
    S_LOAD    = 10'b00_0000_1000,
    S_MUL     = 10'b00_0001_0000,
    S_EVAL_LO = 10'b00_0010_0000,
    S_EVAL_HI = 10'b00_0100_0000,
    S_DECIDE  = 10'b00_1000_0000,
    S_QACC    = 10'b01_0000_0000,
    S_QOUT    = 10'b10_0000_0000
  } state_t;

endpackage

/* src/min_line_segment_tree.sv */
// Min line segment tree top level: node memory, shared multiply-add unit and sequencer.
// Minimum Li Chao tree over positions 0..L-1, L being LEAVES rounded up to a power of
// two, with 2L nodes held in one on-chip memory (slope and intercept side by side).
// Every line value is formed by a single shared unit: a signed multiply into a
// register, then a 64-bit add and compare. An insert walks root to leaf, at most
// log2(L)+1 levels, and at each level does a node read, an operand load, three line
// evaluations at mid, lo and hi, then the decision and any node write. A query walks
// leaf x to root; at each node it does a node read, an operand load, a multiply and
// the running minimum, then hands over the result. A clear, and the block after
// reset, sweeps every node back to the empty line at one entry per cycle, with
// in_ready low throughout. Only a query returns a result; it sits in an output
// register and a further item is taken while it waits.
`include "min_line_segment_tree_assert.svh"

module min_line_segment_tree #(
  parameter int LEAVES = 1024
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [mlst_pkg::FUNC_W-1:0]              in_func,
  input  logic signed [mlst_pkg::SLOPE_W-1:0]      in_slope,
  input  logic signed [mlst_pkg::ICPT_W-1:0]       in_intercept,
  input  logic [mlst_pkg::POS_W-1:0]               in_position,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [mlst_pkg::MIN_W-1:0]        out_minimum
);

  localparam int LW    = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int NW    = LW + 1;
  localparam int DEPTH = 1 << NW;
  localparam int PW    = mlst_pkg::OPA_W + NW + 1;

  mlst_pkg::state_t state_r, state_nxt;

  logic [NW-1:0]  v_r, v_nxt;
  logic [NW-1:0]  lo_r, lo_nxt;
  logic [NW-1:0]  hi_r, hi_nxt;
  logic [NW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [LW-1:0]  x_r, x_nxt;
  logic           is_query_r, is_query_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic signed [mlst_pkg::SLOPE_W-1:0] a_r, a_nxt;
  logic signed [mlst_pkg::ICPT_W-1:0]  b_r, b_nxt;
  logic signed [mlst_pkg::OPA_W-1:0]   op_a_r, op_a_nxt;
  logic signed [mlst_pkg::OPB_W-1:0]   op_b_r, op_b_nxt;
  logic signed [PW-1:0]                prod_r, prod_nxt;
  logic signed [mlst_pkg::VAL_W-1:0]   best_r, best_nxt;
  logic signed [mlst_pkg::MIN_W-1:0]   out_minimum_r, out_minimum_nxt;
  logic                                neg_mid_r, neg_mid_nxt;
  logic                                neg_lo_r, neg_lo_nxt;
  logic                                zero_lo_r, zero_lo_nxt;

  // node memory
  logic [mlst_pkg::LINE_W-1:0] mem [DEPTH];
  logic [mlst_pkg::LINE_W-1:0] rdata_r;
  logic                        mem_re;
  logic                        mem_we;
  logic [NW-1:0]               mem_waddr;
  logic [mlst_pkg::LINE_W-1:0] mem_wdata;

  logic signed [mlst_pkg::SLOPE_W-1:0] rd_slope;
  logic signed [mlst_pkg::ICPT_W-1:0]  rd_icpt;

  // shared unit
  logic [NW-1:0]                     mid;
  logic [NW:0]                       mid_sum;
  logic [NW-1:0]                     xsel;
  logic signed [NW:0]                xsel_s;
  logic signed [PW-1:0]              mul_res;
  logic signed [mlst_pkg::VAL_W-1:0] prod_ext;
  logic signed [mlst_pkg::VAL_W-1:0] opb_ext;
  logic signed [mlst_pkg::VAL_W-1:0] sum;
  logic                              sum_neg;
  logic                              sum_zero;
  logic                              swap;
  logic                              go_left;
  logic                              go_right;

  assign rd_slope = rdata_r[mlst_pkg::LINE_W-1:mlst_pkg::ICPT_W];
  assign rd_icpt  = rdata_r[mlst_pkg::ICPT_W-1:0];

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[NW:1];

  always_comb begin
    case (state_r)
      mlst_pkg::S_MUL:     xsel = is_query_r ? {1'b0, x_r} : mid;
      mlst_pkg::S_EVAL_LO: xsel = lo_r;
      mlst_pkg::S_EVAL_HI: xsel = hi_r;
      default:             xsel = hi_r;
    endcase
  end

  assign xsel_s   = $signed({1'b0, xsel});
  assign mul_res  = op_a_r * xsel_s;
  assign prod_ext = {{(mlst_pkg::VAL_W-PW){prod_r[PW-1]}}, prod_r};
  assign opb_ext  = {op_b_r[mlst_pkg::OPB_W-1], op_b_r};
  assign sum      = prod_ext + opb_ext;
  assign sum_neg  = sum[mlst_pkg::VAL_W-1];
  assign sum_zero = (sum == '0);

  // sum is (new - stored) at x; after a swap the loser is the stored line, so the sign flips
  assign swap     = neg_mid_r;
  assign go_left  = swap ? (!neg_lo_r && !zero_lo_r) : neg_lo_r;
  assign go_right = swap ? (!sum_neg && !sum_zero) : sum_neg;

  assign in_ready    = (state_r == mlst_pkg::S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_minimum = out_minimum_r;

  always_comb begin
    state_nxt       = state_r;
    v_nxt           = v_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    clr_cnt_nxt     = clr_cnt_r;
    x_nxt           = x_r;
    is_query_nxt    = is_query_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    a_nxt           = a_r;
    b_nxt           = b_r;
    op_a_nxt        = op_a_r;
    op_b_nxt        = op_b_r;
    prod_nxt        = prod_r;
    best_nxt        = best_r;
    out_minimum_nxt = out_minimum_r;
    neg_mid_nxt     = neg_mid_r;
    neg_lo_nxt      = neg_lo_r;
    zero_lo_nxt     = zero_lo_r;
    mem_re          = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = clr_cnt_r;
    mem_wdata       = {{mlst_pkg::SLOPE_W{1'b0}}, mlst_pkg::EMPTY_ICPT};

    case (state_r)
      mlst_pkg::S_CLR: begin
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + NW'(1);
        if (clr_cnt_r == {NW{1'b1}}) begin
          state_nxt = mlst_pkg::S_IDLE;
        end
      end
      mlst_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_func)
            mlst_pkg::FUNC_INSERT: begin
              a_nxt        = in_slope;
              b_nxt        = in_intercept;
              lo_nxt       = '0;
              hi_nxt       = NW'(1) << LW;
              v_nxt        = NW'(1);
              is_query_nxt = 1'b0;
              state_nxt    = mlst_pkg::S_RD;
            end
            mlst_pkg::FUNC_QUERY: begin
              x_nxt        = LW'(in_position);
              v_nxt        = {1'b1, LW'(in_position)};
              best_nxt     = mlst_pkg::EMPTY_VAL;
              is_query_nxt = 1'b1;
              state_nxt    = mlst_pkg::S_RD;
            end
            mlst_pkg::FUNC_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = mlst_pkg::S_CLR;
            end
            default: begin
              state_nxt = mlst_pkg::S_IDLE;
            end
          endcase
        end
      end
      mlst_pkg::S_RD: begin
        mem_re    = 1'b1;
        state_nxt = mlst_pkg::S_LOAD;
      end
      mlst_pkg::S_LOAD: begin
        if (is_query_r) begin
          op_a_nxt = {rd_slope[mlst_pkg::SLOPE_W-1], rd_slope};
          op_b_nxt = {rd_icpt[mlst_pkg::ICPT_W-1], rd_icpt};
        end else begin
          op_a_nxt = {a_r[mlst_pkg::SLOPE_W-1], a_r} - {rd_slope[mlst_pkg::SLOPE_W-1], rd_slope};
          op_b_nxt = {b_r[mlst_pkg::ICPT_W-1], b_r} - {rd_icpt[mlst_pkg::ICPT_W-1], rd_icpt};
        end
        state_nxt = mlst_pkg::S_MUL;
      end
      mlst_pkg::S_MUL: begin
        prod_nxt  = mul_res;
        state_nxt = is_query_r ? mlst_pkg::S_QACC : mlst_pkg::S_EVAL_LO;
      end
      mlst_pkg::S_EVAL_LO: begin
        prod_nxt    = mul_res;
        neg_mid_nxt = sum_neg;
        state_nxt   = mlst_pkg::S_EVAL_HI;
      end
      mlst_pkg::S_EVAL_HI: begin
        prod_nxt    = mul_res;
        neg_lo_nxt  = sum_neg;
        zero_lo_nxt = sum_zero;
        state_nxt   = mlst_pkg::S_DECIDE;
      end
      mlst_pkg::S_DECIDE: begin
        if (swap) begin
          mem_we    = 1'b1;
          mem_waddr = v_r;
          mem_wdata = {a_r, b_r};
          a_nxt     = rd_slope;
          b_nxt     = rd_icpt;
        end
        if (v_r[NW-1]) begin
          state_nxt = mlst_pkg::S_IDLE;
        end else if (go_left) begin
          hi_nxt    = mid;
          v_nxt     = {v_r[NW-2:0], 1'b0};
          state_nxt = mlst_pkg::S_RD;
        end else if (go_right) begin
          lo_nxt    = mid;
          v_nxt     = {v_r[NW-2:0], 1'b1};
          state_nxt = mlst_pkg::S_RD;
        end else begin
          state_nxt = mlst_pkg::S_IDLE;
        end
      end
      mlst_pkg::S_QACC: begin
        if (sum < best_r) begin
          best_nxt = sum;
        end
        if (v_r == NW'(1)) begin
          state_nxt = mlst_pkg::S_QOUT;
        end else begin
          v_nxt     = v_r >> 1;
          state_nxt = mlst_pkg::S_RD;
        end
      end
      mlst_pkg::S_QOUT: begin
        // hold until the output register is free or being transferred
        if (!out_valid_r || out_ready) begin
          out_minimum_nxt = best_r[mlst_pkg::MIN_W-1:0];
          out_valid_nxt   = 1'b1;
          state_nxt       = mlst_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mlst_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlst_pkg::S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      is_query_r  <= 1'b0;
      v_r         <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      is_query_r  <= is_query_nxt;
      v_r         <= v_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r           <= x_nxt;
    a_r           <= a_nxt;
    b_r           <= b_nxt;
    op_a_r        <= op_a_nxt;
    op_b_r        <= op_b_nxt;
    prod_r        <= prod_nxt;
    best_r        <= best_nxt;
    out_minimum_r <= out_minimum_nxt;
    neg_mid_r     <= neg_mid_nxt;
    neg_lo_r      <= neg_lo_nxt;
    zero_lo_r     <= zero_lo_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[v_r];
    end
  end

  `MLST_ASSERT_IMP(a_mem_port_excl, clk, rst_n, mem_we, !mem_re)
  `MLST_ASSERT_NXT(a_leaf_ends_walk, clk, rst_n, (state_r == mlst_pkg::S_DECIDE) && v_r[NW-1], state_r == mlst_pkg::S_IDLE)
  `MLST_ASSERT_IMP(a_result_from_query, clk, rst_n, $rose(out_valid_r), $past(state_r == mlst_pkg::S_QOUT))
  `MLST_ASSERT_IMP(a_best_bounded, clk, rst_n, state_r == mlst_pkg::S_QOUT, best_r <= mlst_pkg::EMPTY_VAL)

endmodule
